@@ rtl/pmck_pkg.sv @@
package pmck_pkg;

  localparam int DATA_W = 32;
  localparam int GAIN_W = 31;
  localparam int NUM_STAGES = 11;

  typedef enum logic [1:0] {
    CMD_PREDICT = 2'd0,
    CMD_RELAX   = 2'd1,
    CMD_CORRECT = 2'd2,
    CMD_PASS    = 2'd3
  } pmck_cmd_t;

  typedef enum logic [1:0] {
    REG_DIFFUSION_GAIN       = 2'd0,
    REG_ADVECTION_GAIN       = 2'd1,
    REG_PRESSURE_SOURCE_GAIN = 2'd2,
    REG_CORRECTION_GAIN      = 2'd3
  } pmck_reg_t;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] center_value;
    logic signed [DATA_W-1:0] own_plus;
    logic signed [DATA_W-1:0] own_minus;
    logic signed [DATA_W-1:0] cross_plus;
    logic signed [DATA_W-1:0] cross_minus;
    logic signed [DATA_W-1:0] side_a;
    logic signed [DATA_W-1:0] side_b;
    logic signed [DATA_W-1:0] side_c;
    logic signed [DATA_W-1:0] side_d;
  } pmck_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_value;
    logic [GAIN_W-1:0]        change_size;
    logic                     clipped;
  } pmck_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] diffusion;
    logic [GAIN_W-1:0] advection;
    logic [GAIN_W-1:0] pressure_source;
    logic [GAIN_W-1:0] correction;
  } pmck_gains_t;

endpackage

@@ rtl/pmck_datapath.sv @@
module pmck_datapath import pmck_pkg::*; (
  input  logic                  clk,
  input  logic [NUM_STAGES-1:0] en,
  input  pmck_gains_t           gains,
  input  pmck_in_t              in_data,
  output pmck_out_t             out_data
);

  // stage 0: input register
  pmck_in_t s0_in;

  // stage 1: sums and differences
  pmck_cmd_t          s1_cmd;
  logic signed [31:0] s1_c;
  logic signed [34:0] s1_lap;
  logic signed [32:0] s1_do;
  logic signed [32:0] s1_dx;
  logic signed [33:0] s1_sq;
  logic signed [33:0] s1_sp;
  logic signed [33:0] s1_s4;

  // stage 2: products
  pmck_cmd_t          s2_cmd;
  logic signed [31:0] s2_c;
  logic signed [64:0] s2_p1;
  logic signed [66:0] s2_p2;
  logic signed [66:0] s2_p3;
  logic signed [31:0] s2_q;

  // stage 3: rounded terms
  pmck_cmd_t          s3_cmd;
  logic signed [31:0] s3_c;
  logic signed [40:0] s3_t1;
  logic signed [40:0] s3_t2;
  logic signed [42:0] s3_r3;
  logic signed [31:0] s3_q;

  // stage 4: advection operand
  pmck_cmd_t          s4_cmd;
  logic signed [31:0] s4_c;
  logic signed [41:0] s4_s;
  logic signed [42:0] s4_r3;
  logic signed [31:0] s4_q;

  // stage 5: advection partial products
  pmck_cmd_t          s5_cmd;
  logic signed [31:0] s5_c;
  logic [51:0]        s5_pl;
  logic signed [52:0] s5_ph;
  logic               s5_neg;
  logic signed [42:0] s5_r3;
  logic signed [31:0] s5_q;

  // stage 6: rounded advection
  pmck_cmd_t          s6_cmd;
  logic signed [31:0] s6_c;
  logic signed [49:0] s6_adv;
  logic signed [42:0] s6_r3;
  logic signed [31:0] s6_q;

  // stage 7: unsaturated result
  pmck_cmd_t          s7_cmd;
  logic signed [31:0] s7_c;
  logic signed [49:0] s7_v;

  // stage 8: saturated result
  pmck_cmd_t          s8_cmd;
  logic signed [31:0] s8_c;
  logic signed [31:0] s8_nv;
  logic               s8_clip;

  // stage 9: pressure change
  pmck_cmd_t          s9_cmd;
  logic signed [31:0] s9_nv;
  logic signed [32:0] s9_d;
  logic               s9_clip;

  pmck_out_t s10_out;

  logic signed [34:0] lap_next;
  logic signed [32:0] do_next;
  logic signed [32:0] dx_next;
  logic signed [33:0] sq_next;
  logic signed [33:0] sp_next;
  logic signed [33:0] s4_next;

  logic [GAIN_W-1:0]  g_sel;
  logic signed [34:0] x3_sel;
  logic signed [33:0] q_sum;
  logic signed [64:0] p1_next;
  logic signed [66:0] p2_next;
  logic signed [66:0] p3_next;

  logic signed [64:0] t1_sum;
  logic signed [66:0] t2_sum;
  logic signed [66:0] r3_sum;

  logic [51:0]        pl_next;
  logic signed [52:0] ph_next;
  logic signed [73:0] adv_sum;

  logic signed [49:0] v_next;
  logic               v_in_range;

  logic [32:0]        d_mag;
  logic               d_over;
  logic               relax;

  // stage 0
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_in <= in_data;
    end
  end

  // stage 1
  always_comb begin
    lap_next = 35'(s0_in.own_plus) + 35'(s0_in.own_minus) + 35'(s0_in.cross_plus)
             + 35'(s0_in.cross_minus) - (35'(s0_in.center_value) <<< 2);
    do_next  = 33'(s0_in.own_plus) - 33'(s0_in.own_minus);
    dx_next  = 33'(s0_in.cross_plus) - 33'(s0_in.cross_minus);
    sq_next  = 34'(s0_in.side_a) + 34'(s0_in.side_b) + 34'(s0_in.side_c)
             + 34'(s0_in.side_d);
    sp_next  = 34'(s0_in.side_a) - 34'(s0_in.side_b) + 34'(s0_in.side_c)
             - 34'(s0_in.side_d);
    s4_next  = 34'(s0_in.own_plus) + 34'(s0_in.own_minus) + 34'(s0_in.cross_plus)
             + 34'(s0_in.cross_minus);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_cmd <= pmck_cmd_t'(s0_in.command);
      s1_c   <= s0_in.center_value;
      s1_lap <= lap_next;
      s1_do  <= do_next;
      s1_dx  <= dx_next;
      s1_sq  <= sq_next;
      s1_sp  <= sp_next;
      s1_s4  <= s4_next;
    end
  end

  // stage 2
  always_comb begin
    case (s1_cmd)
      CMD_PREDICT: begin
        g_sel  = gains.diffusion;
        x3_sel = s1_lap;
      end
      CMD_RELAX: begin
        g_sel  = gains.pressure_source;
        x3_sel = 35'(s1_sp);
      end
      CMD_CORRECT: begin
        g_sel  = gains.correction;
        x3_sel = 35'(s1_do);
      end
      default: begin
        g_sel  = gains.correction;
        x3_sel = 35'(s1_do);
      end
    endcase
    q_sum   = s1_s4 + 34'sd2 - $signed({33'd0, s1_s4[33]});
    p1_next = s1_c * s1_do;
    p2_next = s1_sq * s1_dx;
    p3_next = $signed({1'b0, g_sel}) * x3_sel;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_cmd <= s1_cmd;
      s2_c   <= s1_c;
      s2_p1  <= p1_next;
      s2_p2  <= p2_next;
      s2_p3  <= p3_next;
      s2_q   <= q_sum[33:2];
    end
  end

  // stage 3: round half away from zero
  always_comb begin
    t1_sum = s2_p1 + 65'sd8388608 - $signed({64'd0, s2_p1[64]});
    t2_sum = s2_p2 + 67'sd33554432 - $signed({66'd0, s2_p2[66]});
    r3_sum = s2_p3 + 67'sd8388608 - $signed({66'd0, s2_p3[66]});
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_cmd <= s2_cmd;
      s3_c   <= s2_c;
      s3_t1  <= t1_sum[64:24];
      s3_t2  <= t2_sum[66:26];
      s3_r3  <= r3_sum[66:24];
      s3_q   <= s2_q;
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_cmd <= s3_cmd;
      s4_c   <= s3_c;
      s4_s   <= 42'(s3_t1) + 42'(s3_t2);
      s4_r3  <= s3_r3;
      s4_q   <= s3_q;
    end
  end

  // stage 5
  always_comb begin
    pl_next = gains.advection * s4_s[20:0];
    ph_next = $signed({1'b0, gains.advection}) * $signed(s4_s[41:21]);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_cmd <= s4_cmd;
      s5_c   <= s4_c;
      s5_pl  <= pl_next;
      s5_ph  <= ph_next;
      s5_neg <= s4_s[41];
      s5_r3  <= s4_r3;
      s5_q   <= s4_q;
    end
  end

  // stage 6
  always_comb begin
    adv_sum = $signed({s5_ph, 21'd0}) + $signed({22'd0, s5_pl}) + 74'sd8388608
            - $signed({73'd0, s5_neg});
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_cmd <= s5_cmd;
      s6_c   <= s5_c;
      s6_adv <= adv_sum[73:24];
      s6_r3  <= s5_r3;
      s6_q   <= s5_q;
    end
  end

  // stage 7
  always_comb begin
    case (s6_cmd)
      CMD_PREDICT: v_next = 50'(s6_c) + 50'(s6_r3) - s6_adv;
      CMD_RELAX:   v_next = 50'(s6_q) - 50'(s6_r3);
      CMD_CORRECT: v_next = 50'(s6_c) - 50'(s6_r3);
      default:     v_next = 50'(s6_c);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_cmd <= s6_cmd;
      s7_c   <= s6_c;
      s7_v   <= v_next;
    end
  end

  // stage 8
  assign v_in_range = (&s7_v[49:31]) | ~(|s7_v[49:31]);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_cmd  <= s7_cmd;
      s8_c    <= s7_c;
      s8_clip <= ~v_in_range;
      if (v_in_range) begin
        s8_nv <= s7_v[31:0];
      end else if (s7_v[49]) begin
        s8_nv <= 32'sh80000000;
      end else begin
        s8_nv <= 32'sh7FFFFFFF;
      end
    end
  end

  // stage 9
  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_cmd  <= s8_cmd;
      s9_nv   <= s8_nv;
      s9_d    <= 33'(s8_nv) - 33'(s8_c);
      s9_clip <= s8_clip;
    end
  end

  // stage 10: output register
  always_comb begin
    d_mag  = s9_d[32] ? 33'(-s9_d) : 33'(s9_d);
    d_over = |d_mag[32:31];
    relax  = (s9_cmd == CMD_RELAX);
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_out.new_value <= s9_nv;
      s10_out.clipped   <= s9_clip | (relax & d_over);
      if (!relax) begin
        s10_out.change_size <= '0;
      end else if (d_over) begin
        s10_out.change_size <= '1;
      end else begin
        s10_out.change_size <= d_mag[30:0];
      end
    end
  end

  assign out_data = s10_out;

endmodule

@@ rtl/projection_method_cell_kernel.sv @@
// Per-cell stencil kernel for a staggered-grid projection flow solver, all values
// signed Q8.24. Command 0 predicts a velocity from diffusion and advection terms,
// command 1 relaxes a pressure and reports the size of its change, command 2
// corrects a velocity by a pressure difference, command 3 passes the center value.
// The block takes one beat per cycle while in_ready is high and returns one result
// beat per input beat, in order, through the eleven-stage arithmetic pipeline,
// whose longest path is one 32-by-35-bit multiply. Stalls on the output back up
// stage by stage, and empty stages fill while the output waits. The user must
// write gains through the cfg port only while no beat is in flight; the block
// itself does not enforce this.
module projection_method_cell_kernel import pmck_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pmck_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pmck_out_t         out_data,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [GAIN_W-1:0] cfg_data
);

  pmck_gains_t           gains;
  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg_write) begin
      case (pmck_reg_t'(cfg_index))
        REG_DIFFUSION_GAIN:       gains.diffusion       <= cfg_data;
        REG_ADVECTION_GAIN:       gains.advection       <= cfg_data;
        REG_PRESSURE_SOURCE_GAIN: gains.pressure_source <= cfg_data;
        REG_CORRECTION_GAIN:      gains.correction      <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or its beat moves on
  always_comb begin
    en[NUM_STAGES-1] = ~stage_valid[NUM_STAGES-1] | out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = ~stage_valid[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = stage_valid[NUM_STAGES-1];

  pmck_datapath u_datapath (
    .clk      (clk),
    .en       (en),
    .gains    (gains),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ test/tb_projection_method_cell_kernel.sv @@
`timescale 1ns / 1ps

module tb_projection_method_cell_kernel;
  import pmck_pkg::*;

  localparam logic [DATA_W-1:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] W_MIN = 32'h8000_0000;
  localparam logic [GAIN_W-1:0] G_MAX = 31'h7FFF_FFFF;
  localparam logic [GAIN_W-1:0] G_ONE = 31'd16777216;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_CELLS = 145;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pmck_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pmck_out_t         out_data;
  logic              cfg_write = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  logic [GAIN_W-1:0] gain_diff = '0;
  logic [GAIN_W-1:0] gain_adv = '0;
  logic [GAIN_W-1:0] gain_src = '0;
  logic [GAIN_W-1:0] gain_corr = '0;

  pmck_in_t  pending_cells[$];
  pmck_out_t expected_cells[$];
  bit        no_idle = 1'b0;
  int        error_count = 0;
  int        cycle_count = 0;

  projection_method_cell_kernel dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint scaled_product(longint a, longint b, int unsigned sh);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] prod;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    prod = (ma * mb + (128'd1 << (sh - 1))) >> sh;
    scaled_product = neg ? -longint'({2'b00, prod[61:0]}) : longint'({2'b00, prod[61:0]});
  endfunction

  function automatic pmck_out_t predict_cell(pmck_in_t x);
    longint c, op, om, xp, xm, sa, sb, sc, sd;
    longint nv, t1, t2, dlt;
    logic   clip;
    pmck_out_t r;
    c  = $signed(x.center_value);
    op = $signed(x.own_plus);
    om = $signed(x.own_minus);
    xp = $signed(x.cross_plus);
    xm = $signed(x.cross_minus);
    sa = $signed(x.side_a);
    sb = $signed(x.side_b);
    sc = $signed(x.side_c);
    sd = $signed(x.side_d);
    clip = 1'b0;
    r = '0;
    case (pmck_cmd_t'(x.command))
      CMD_PREDICT: begin
        t1 = scaled_product(c, op - om, 24);
        t2 = scaled_product(sa + sb + sc + sd, xp - xm, 26);
        nv = c + scaled_product(longint'(gain_diff), op + om + xp + xm - 4 * c, 24)
             - scaled_product(longint'(gain_adv), t1 + t2, 24);
      end
      CMD_RELAX: begin
        nv = scaled_product(op + om + xp + xm, longint'(1) << 24, 26)
             - scaled_product(longint'(gain_src), sa - sb + sc - sd, 24);
      end
      CMD_CORRECT: begin
        nv = c - scaled_product(longint'(gain_corr), op - om, 24);
      end
      default: begin
        nv = c;
      end
    endcase
    if (nv > SAT_HI) begin
      nv = SAT_HI;
      clip = 1'b1;
    end else if (nv < SAT_LO) begin
      nv = SAT_LO;
      clip = 1'b1;
    end
    if (pmck_cmd_t'(x.command) == CMD_RELAX) begin
      dlt = nv - c;
      if (dlt < 0) dlt = -dlt;
      if (dlt > SAT_HI) begin
        dlt = SAT_HI;
        clip = 1'b1;
      end
      r.change_size = dlt[GAIN_W-1:0];
    end
    r.new_value = nv[DATA_W-1:0];
    r.clipped = clip;
    return r;
  endfunction

  function automatic pmck_in_t make_cell(pmck_cmd_t cmd, logic [31:0] c, logic [31:0] op,
                                         logic [31:0] om, logic [31:0] xp, logic [31:0] xm,
                                         logic [31:0] a, logic [31:0] b, logic [31:0] cc,
                                         logic [31:0] d);
    pmck_in_t x;
    x.command = cmd;
    x.center_value = c;
    x.own_plus = op;
    x.own_minus = om;
    x.cross_plus = xp;
    x.cross_minus = xm;
    x.side_a = a;
    x.side_b = b;
    x.side_c = cc;
    x.side_d = d;
    return x;
  endfunction

  function automatic logic [31:0] pick_word(int unsigned scale);
    case ($urandom_range(0, 9))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return $urandom;
      default: return $signed($urandom) >>> scale;
    endcase
  endfunction

  function automatic pmck_in_t random_cell();
    int unsigned scale;
    int unsigned pick;
    pmck_cmd_t   cmd;
    scale = $urandom_range(0, 24);
    pick = $urandom_range(0, 9);
    if (pick < 3) cmd = CMD_PREDICT;
    else if (pick < 6) cmd = CMD_RELAX;
    else if (pick < 9) cmd = CMD_CORRECT;
    else cmd = CMD_PASS;
    return make_cell(cmd, pick_word(scale), pick_word(scale), pick_word(scale),
                     pick_word(scale), pick_word(scale), pick_word(scale),
                     pick_word(scale), pick_word(scale), pick_word(scale));
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    return GAIN_W'($urandom >> $urandom_range(0, 31));
  endfunction

  task automatic add_pending(pmck_in_t x);
    pending_cells = {pending_cells, x};
  endtask

  task automatic write_gain(pmck_reg_t idx, logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DIFFUSION_GAIN:       gain_diff = val;
      REG_ADVECTION_GAIN:       gain_adv = val;
      REG_PRESSURE_SOURCE_GAIN: gain_src = val;
      default:                  gain_corr = val;
    endcase
  endtask

  task automatic program_gains(logic [GAIN_W-1:0] gd, logic [GAIN_W-1:0] ga,
                               logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gc);
    write_gain(REG_DIFFUSION_GAIN, gd);
    write_gain(REG_ADVECTION_GAIN, ga);
    write_gain(REG_PRESSURE_SOURCE_GAIN, gp);
    write_gain(REG_CORRECTION_GAIN, gc);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_cells.size() != 0 || expected_cells.size() != 0 || in_valid)
      @(posedge clk);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_cells = {expected_cells, predict_cell(in_data)};
      if (pending_cells.size() != 0 && (no_idle || $urandom_range(99) >= 38)) begin
        in_data <= pending_cells.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    pmck_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cells.size() == 0) begin
          $error("result beat with no expected value: %h", out_data);
          error_count++;
        end else begin
          want = expected_cells.pop_front();
          if (out_data.new_value !== want.new_value) begin
            $error("new_value expected %h got %h", want.new_value, out_data.new_value);
            error_count++;
          end
          if (out_data.change_size !== want.change_size) begin
            $error("change_size expected %h got %h", want.change_size, out_data.change_size);
            error_count++;
          end
          if (out_data.clipped !== want.clipped) begin
            $error("clipped expected %b got %b", want.clipped, out_data.clipped);
            error_count++;
          end
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    pmck_cmd_t cmd_list[4];
    cmd_list = '{CMD_PREDICT, CMD_RELAX, CMD_CORRECT, CMD_PASS};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    program_gains(G_ONE, G_ONE, G_ONE, G_ONE);
    foreach (cmd_list[k]) begin
      add_pending(make_cell(cmd_list[k], W_MAX, W_MAX, W_MAX, W_MAX, W_MAX,
                            W_MAX, W_MAX, W_MAX, W_MAX));
      add_pending(make_cell(cmd_list[k], W_MIN, W_MIN, W_MIN, W_MIN, W_MIN,
                            W_MIN, W_MIN, W_MIN, W_MIN));
      add_pending(make_cell(cmd_list[k], 0, 0, 0, 0, 0, 0, 0, 0, 0));
    end
    add_pending(make_cell(CMD_RELAX, W_MIN, W_MAX, W_MAX, W_MAX, W_MAX,
                          0, 0, 0, 0));
    add_pending(make_cell(CMD_PREDICT, 32'sd8388608, 1, 0, 0, 0, 0, 0, 0, 0));
    add_pending(make_cell(CMD_PREDICT, -32'sd8388608, 1, 0, 0, 0, 0, 0, 0, 0));
    add_pending(make_cell(CMD_RELAX, 0, 2, 0, 0, 0, 0, 0, 0, 0));
    add_pending(make_cell(CMD_RELAX, 0, -32'sd2, 0, 0, 0, 0, 0, 0, 0));
    add_pending(make_cell(CMD_CORRECT, W_MIN, W_MAX, W_MIN, 0, 0, 0, 0, 0, 0));
    add_pending(make_cell(CMD_CORRECT, W_MAX, W_MIN, W_MAX, 0, 0, 0, 0, 0, 0));
    add_pending(make_cell(CMD_PREDICT, W_MAX, W_MAX, W_MIN, W_MAX, W_MIN,
                          W_MAX, W_MAX, W_MAX, W_MAX));
    wait_drained();

    for (int p = 1; p < NUM_PHASES; p++) begin
      case (p)
        1: program_gains(0, 0, 0, 0);
        2: program_gains(G_MAX, G_MAX, G_MAX, G_MAX);
        3: program_gains(31'd1677722, 31'd838861, 31'd4194304, 31'd8388608);
        default: program_gains(random_gain(), random_gain(), random_gain(), random_gain());
      endcase
      no_idle = (p == 5);
      repeat (PHASE_CELLS) add_pending(random_cell());
      wait_drained();
    end
    no_idle = 1'b0;

    if (expected_cells.size() != 0) error_count++;
    if (error_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
rtl/pmck_pkg.sv
rtl/pmck_datapath.sv
rtl/projection_method_cell_kernel.sv
test/tb_projection_method_cell_kernel.sv
